@@ rtl/bscfn_pkg.sv @@
package bscfn_pkg;

   // field widths
   localparam int OP_W     = 3;
   localparam int IDX_W    = 12;
   localparam int SIZE_W   = 13;
   localparam int CNT_W    = 13;
   localparam int STAT_W   = 2;
   localparam int LBYTE_W  = SIZE_W - 3;

   // size register value after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

   // request opcodes
   localparam logic [OP_W-1:0] OP_TEST     = 3'd0;
   localparam logic [OP_W-1:0] OP_SET      = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd2;
   localparam logic [OP_W-1:0] OP_CLR_ALL  = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND     = 3'd4;

   // response status codes
   localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_BAD  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NONE = 2'd2;

   // command queue depth
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

   // classified command kinds
   typedef enum logic [2:0] {
      K_TEST    = 3'd0,
      K_SET     = 3'd1,
      K_CLEAR   = 3'd2,
      K_CLR_ALL = 3'd3,
      K_FIND    = 3'd4,
      K_NOP     = 3'd5,
      K_BAD     = 3'd6
   } kind_type;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [IDX_W-1:0] bit_index;
   } req_payload_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              bit_value;
      logic [IDX_W-1:0]  found_index;
      logic [CNT_W-1:0]  set_count;
   } rsp_payload_type;

   // command passed from the front to the back
   typedef struct packed {
      kind_type           kind;
      logic [IDX_W-1:0]   bit_index;
      logic [LBYTE_W-1:0] last_byte;
      logic [2:0]         last_bit;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

   typedef struct packed {
      logic    avail;
      cmd_type cmd;
   } cmd_head_type;

endpackage

@@ rtl/bscfn_chan_if.sv @@
interface bscfn_req_if;
   import bscfn_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bscfn_rsp_if;
   import bscfn_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/bscfn_front.sv @@
module bscfn_front #(
   parameter int MAX_BITS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   bscfn_req_if.sink                      req_chan,
   input  logic                           csr_wr_en,
   input  logic [bscfn_pkg::SIZE_W-1:0]   csr_wr_data,
   input  logic                           accept_en,
   input  logic                           q_full,
   output bscfn_pkg::cmd_push_type        push
);
   import bscfn_pkg::*;

   localparam logic [16:0] MAX_C = 17'(MAX_BITS);

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] size_in;
   logic [SIZE_W-1:0] eff_size;
   logic [SIZE_W-1:0] last_pos;
   logic              bad;
   kind_type          kind;

   // size register
   always_comb begin
      size_in = size_ff;
      if (csr_wr_en) begin
         size_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // effective size and range check
   assign eff_size = ({4'b0, size_ff} < MAX_C) ? size_ff : MAX_C[SIZE_W-1:0];
   assign bad      = {1'b0, req_chan.payload.bit_index} >= eff_size;
   assign last_pos = eff_size - 13'd1;

   // classify the request
   always_comb begin
      unique case (req_chan.payload.opcode)
         OP_TEST:    kind = bad ? K_BAD : K_TEST;
         OP_SET:     kind = bad ? K_BAD : K_SET;
         OP_CLEAR:   kind = bad ? K_BAD : K_CLEAR;
         OP_CLR_ALL: kind = K_CLR_ALL;
         OP_FIND:    kind = bad ? K_BAD : K_FIND;
         default:    kind = K_NOP;
      endcase
   end

   // handshake and queue push
   assign req_chan.ready      = accept_en && !q_full;
   assign push.valid          = req_chan.valid && req_chan.ready;
   assign push.cmd.kind       = kind;
   assign push.cmd.bit_index  = req_chan.payload.bit_index;
   assign push.cmd.last_byte  = last_pos[SIZE_W-1:3];
   assign push.cmd.last_bit   = last_pos[2:0];

endmodule

@@ rtl/bscfn_cmd_fifo.sv @@
module bscfn_cmd_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  bscfn_pkg::cmd_push_type   push,
   input  logic                      pop,
   output bscfn_pkg::cmd_head_type   head,
   output logic                      full
);
   import bscfn_pkg::*;

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff;
   logic [CMD_PTR_W-1:0]   wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff;
   logic [CMD_PTR_W-1:0]   rd_ptr_in;
   logic [CMD_PTR_W:0]     fill_ff;
   logic [CMD_PTR_W:0]     fill_in;
   logic                   do_pop;

   assign full       = fill_ff == (CMD_PTR_W+1)'(CMD_DEPTH);
   assign head.avail = fill_ff != '0;
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.avail;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("command queue overflow");
`endif

endmodule

@@ rtl/bscfn_back.sv @@
module bscfn_back #(
   parameter int MAX_BITS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bscfn_pkg::cmd_head_type   head,
   output logic                      pop,
   output logic                      accept_en,
   bscfn_rsp_if.source               rsp_chan
);
   import bscfn_pkg::*;

   localparam int DEPTH  = (MAX_BITS + 7) / 8;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_DONE  = 4'b1000
   } back_state_type;

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [ADDR_W-1:0]   scan_ff, scan_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic                first_ff, first_in;
   logic                owe_ff, owe_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic                value_ff, value_in;
   logic [IDX_W-1:0]    found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic [7:0]          mem [DEPTH];
   logic [7:0]          rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wa;
   logic [7:0]          mem_wd;

   logic [7:0]          bit_mask;
   logic                cur_bit;
   logic [7:0]          lo_mask;
   logic [7:0]          hi_mask;
   logic [7:0]          masked;
   logic                at_last;
   logic [2:0]          hit_bit;
   logic [IDX_W-1:0]    found_pos;

   // byte store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // read address: head byte on dispatch, next byte while scanning
   assign rd_addr = (state_ff == ST_IDLE) ? ADDR_W'(head.cmd.bit_index[IDX_W-1:3])
                                          : scan_ff + 1'b1;

   // bit select for test, set and clear
   assign bit_mask = 8'b1 << cmd_ff.bit_index[2:0];
   assign cur_bit  = |(rd_data_ff & bit_mask);

   // find: mask bits below the start and beyond the size, then pick lowest
   assign at_last = 16'(scan_ff) == 16'(cmd_ff.last_byte);
   assign lo_mask = first_ff ? (8'hFF << cmd_ff.bit_index[2:0]) : 8'hFF;
   assign hi_mask = at_last ? (8'hFF >> (3'd7 - cmd_ff.last_bit)) : 8'hFF;
   assign masked  = rd_data_ff & lo_mask & hi_mask;

   always_comb begin
      hit_bit = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (masked[i]) begin
            hit_bit = 3'(i);
         end
      end
   end

   assign found_pos = IDX_W'({scan_ff, hit_bit});

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      scan_in      = scan_ff;
      clr_in       = clr_ff;
      first_in     = first_ff;
      owe_in       = owe_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = scan_ff;
      mem_wd       = rd_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = 8'h00;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_in   = '0;
               owe_in   = 1'b0;
               state_in = owe_ff ? ST_DONE : ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (head.avail) begin
               pop       = 1'b1;
               cmd_in    = head.cmd;
               scan_in   = ADDR_W'(head.cmd.bit_index[IDX_W-1:3]);
               first_in  = 1'b1;
               status_in = STATUS_OK;
               value_in  = 1'b0;
               found_in  = '0;
               unique case (head.cmd.kind) inside
                  K_TEST, K_SET, K_CLEAR: begin
                     state_in = ST_EXEC;
                  end
                  K_FIND: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_NONE;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_EXEC;
                     end
                  end
                  K_CLR_ALL: begin
                     count_in = '0;
                     clr_in   = '0;
                     owe_in   = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  K_BAD: begin
                     status_in = STATUS_BAD;
                     state_in  = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_EXEC: begin
            unique case (cmd_ff.kind) inside
               K_TEST: begin
                  value_in = cur_bit;
                  state_in = ST_DONE;
               end
               K_SET: begin
                  if (!cur_bit) begin
                     mem_we   = 1'b1;
                     mem_wd   = rd_data_ff | bit_mask;
                     count_in = count_ff + 1'b1;
                  end
                  state_in = ST_DONE;
               end
               K_CLEAR: begin
                  if (cur_bit) begin
                     mem_we   = 1'b1;
                     mem_wd   = rd_data_ff & ~bit_mask;
                     count_in = count_ff - 1'b1;
                  end
                  state_in = ST_DONE;
               end
               K_FIND: begin
                  first_in = 1'b0;
                  if (|masked) begin
                     found_in = found_pos;
                     state_in = ST_DONE;
                  end else if (at_last) begin
                     status_in = STATUS_NONE;
                     state_in  = ST_DONE;
                  end else begin
                     scan_in = scan_ff + 1'b1;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.bit_value   = value_ff;
               rsp_data_in.found_index = found_ff;
               rsp_data_in.set_count   = count_ff;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         owe_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         owe_ff       <= owe_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      scan_ff     <= scan_in;
      first_ff    <= first_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign accept_en        = state_ff != ST_CLEAR;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 13'd4096)
      else $error("set count beyond bitmap capacity");

   a_set_counts_up: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && cmd_ff.kind == K_SET && !cur_bit)
      |=> count_ff == $past(count_ff) + 13'd1)
      else $error("set of a clear bit did not bump the count");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && cmd_ff.kind == K_FIND)
      |-> 16'(scan_ff) <= 16'(cmd_ff.last_byte))
      else $error("find walked past the last valid byte");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !pop)
      else $error("command taken during clearing pass");
`endif

endmodule

@@ rtl/bitmap_set_clear_find_next_unit.sv @@
// back end: takes the queue head in idle, reads its byte, executes (a find walks
//   byte by byte up to the last byte in use), then registers the response; no-op,
//   out-of-range and find on an empty map skip execution; the back end holds off
//   while its response waits, and a two-entry queue sits ahead of it
// reset: synchronous, clears the count, then a clearing pass over the (MAX_BITS+7)/8
//   bytes of the byte store (512 by default) during which no request is taken
module bitmap_set_clear_find_next_unit #(
   parameter int MAX_BITS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   bscfn_req_if.sink                      req_chan,
   bscfn_rsp_if.source                    rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [bscfn_pkg::SIZE_W-1:0]   csr_wr_data
);
   import bscfn_pkg::*;

   cmd_push_type push;
   cmd_head_type head;
   logic         pop;
   logic         q_full;
   logic         accept_en;

   // request classification and size register
   bscfn_front #(
      .MAX_BITS (MAX_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept_en   (accept_en),
      .q_full      (q_full),
      .push        (push)
   );

   // command queue between front and back
   bscfn_cmd_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   // byte store, count and response register
   bscfn_back #(
      .MAX_BITS (MAX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .accept_en (accept_en),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ sim/tb_top.sv @@
module tb_top;
   import bscfn_pkg::*;

   localparam int MAX_BITS    = 4096;
   localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int PRINT_CAP   = 30;

   // opcodes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_SPARE_LO = OP_FIND + 3'd1;
   localparam logic [OP_W-1:0] OP_SPARE_MID = OP_FIND + 3'd2;
   localparam logic [OP_W-1:0] OP_SPARE_HI = OP_FIND + 3'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   bscfn_req_if req_bus ();
   bscfn_rsp_if rsp_bus ();

   bitmap_set_clear_find_next_unit #(.MAX_BITS(MAX_BITS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the bitmap, its population count and the size register
   logic [7:0]        map_bytes [STORE_BYTES];
   logic [CNT_W-1:0]  ones_total;
   logic [SIZE_W-1:0] size_reg;

   req_payload_type pending_requests [$];
   rsp_payload_type expected_responses [$];

   int     n_queued = 0;
   int     n_accepted = 0;
   int     n_checked = 0;
   int     errors = 0;
   int     finds_hit = 0;
   int     finds_none = 0;
   int     out_of_range = 0;
   longint cycles = 0;

   logic req_fire = 1'b0;
   int   req_gap = 0;
   int   ready_stall = 0;
   int   hold_left = 0;
   bit   no_idle = 1'b0;
   bit   want_backlog = 1'b0;

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // gap length: mostly short, now and then long
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned bits_in_use();
      return (size_reg < MAX_BITS) ? size_reg : MAX_BITS;
   endfunction

   // apply one request to the shadow bitmap and build the response it should give
   function automatic rsp_payload_type apply_request(req_payload_type r);
      rsp_payload_type res;
      int unsigned     lim;
      int unsigned     pos;
      int unsigned     byte_no;
      logic [7:0]      mask;
      bit              bad;
      bit              hit;
      res = '0;
      lim = bits_in_use();
      bad = r.bit_index >= lim;
      byte_no = r.bit_index >> 3;
      mask = 8'd1 << r.bit_index[2:0];
      case (r.opcode)
         OP_TEST: begin
            if (bad) res.status = STATUS_BAD;
            else res.bit_value = |(map_bytes[byte_no] & mask);
         end
         OP_SET: begin
            if (bad) begin
               res.status = STATUS_BAD;
            end else if ((map_bytes[byte_no] & mask) == 8'd0) begin
               map_bytes[byte_no] |= mask;
               ones_total++;
            end
         end
         OP_CLEAR: begin
            if (bad) begin
               res.status = STATUS_BAD;
            end else if ((map_bytes[byte_no] & mask) != 8'd0) begin
               map_bytes[byte_no] &= ~mask;
               ones_total--;
            end
         end
         OP_CLR_ALL: begin
            foreach (map_bytes[i]) map_bytes[i] = '0;
            ones_total = '0;
         end
         OP_FIND: begin
            if (bad) begin
               res.status = STATUS_BAD;
            end else begin
               // walk whole zero bytes, then bit by bit, never past the size in use
               pos = r.bit_index;
               hit = 1'b0;
               while (ones_total != 0 && pos < lim && !hit) begin
                  if (pos % 8 == 0 && map_bytes[pos / 8] == 8'd0) pos += 8;
                  else if (map_bytes[pos / 8][pos % 8]) hit = 1'b1;
                  else pos++;
               end
               if (hit) begin
                  res.found_index = IDX_W'(pos);
                  finds_hit++;
               end else begin
                  res.status = STATUS_NONE;
                  finds_none++;
               end
            end
         end
         default: begin
         end
      endcase
      if (res.status == STATUS_BAD) out_of_range++;
      res.set_count = ones_total;
      return res;
   endfunction

   task automatic report_mismatch(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch at response %0d: %s", n_checked, what);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.payload <= '0;
         req_gap = 0;
      end else if (!req_bus.valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_bus.payload <= pending_requests.pop_front();
            req_bus.valid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready: random stalls plus the long hold-off on demand
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_stall = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (want_backlog) begin
         want_backlog = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (ready_stall > 0) begin
         ready_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) ready_stall = pick_gap();
      end
   end

   // monitor: register writes, response checks, expectations for accepted requests
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      rsp_payload_type got;
      req_fire <= !reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1;
      if (reset) begin
         foreach (map_bytes[i]) map_bytes[i] = '0;
         ones_total = '0;
         size_reg = SIZE_RESET;
      end else begin
         if (csr_wr_en) size_reg = csr_wr_data;
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = rsp_bus.payload;
            if (expected_responses.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_responses.pop_front();
               n_checked++;
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
               if (got.bit_value !== want.bit_value)
                  report_mismatch($sformatf("bit_value %0d, expected %0d",
                                            got.bit_value, want.bit_value));
               if (got.found_index !== want.found_index)
                  report_mismatch($sformatf("found_index %0d, expected %0d",
                                            got.found_index, want.found_index));
               if (got.set_count !== want.set_count)
                  report_mismatch($sformatf("set_count %0d, expected %0d",
                                            got.set_count, want.set_count));
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            expected_responses.push_back(apply_request(req_bus.payload));
            n_accepted++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("run limit of %0d cycles reached, %0d responses still due",
                  CYCLE_LIMIT, expected_responses.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic queue_request(logic [OP_W-1:0] op, int unsigned idx);
      req_payload_type r;
      r.opcode = op;
      r.bit_index = IDX_W'(idx);
      pending_requests.push_back(r);
      n_queued++;
   endtask

   // random request: mostly in range, some at the size boundary, some anywhere
   function automatic req_payload_type random_request();
      req_payload_type r;
      int unsigned     lim;
      int unsigned     pick;
      lim = bits_in_use();
      pick = $urandom_range(0, 99);
      if (pick < 25) r.opcode = OP_FIND;
      else if (pick < 60) r.opcode = OP_SET;
      else if (pick < 77) r.opcode = OP_CLEAR;
      else if (pick < 94) r.opcode = OP_TEST;
      else if (pick < 96) r.opcode = OP_CLR_ALL;
      else r.opcode = OP_SPARE_LO + OP_W'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 70 && lim > 0) r.bit_index = IDX_W'($urandom_range(0, lim - 1));
      else if (pick < 82) r.bit_index = IDX_W'(lim + $urandom_range(0, 2) - 1);
      else r.bit_index = IDX_W'($urandom);
      return r;
   endfunction

   task automatic run_random(int count);
      repeat (count) begin
         pending_requests.push_back(random_request());
         n_queued++;
      end
   endtask

   // block is idle once every queued request has been answered
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (n_accepted != n_queued || expected_responses.size() != 0);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stimulus
   initial begin : stimulus
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty map, repeated set and clear, far end of the map, no-ops
      queue_request(OP_FIND, 0);
      queue_request(OP_TEST, 0);
      queue_request(OP_SET, 0);
      queue_request(OP_SET, 0);
      queue_request(OP_TEST, 0);
      queue_request(OP_SET, 4095);
      queue_request(OP_FIND, 0);
      queue_request(OP_FIND, 1);
      queue_request(OP_CLEAR, 0);
      queue_request(OP_CLEAR, 0);
      queue_request(OP_FIND, 0);
      queue_request(OP_SPARE_LO, 12'hABC);
      queue_request(OP_SPARE_HI, 12'hFFF);
      queue_request(OP_SET, 9);
      queue_request(OP_FIND, 8);
      queue_request(OP_CLR_ALL, 12'hFFF);
      queue_request(OP_TEST, 4095);
      queue_request(OP_SET, 4095);
      queue_request(OP_SET, 3);

      // shrink: bits left beyond the size must never be found
      write_size(13'd8);
      queue_request(OP_FIND, 4);
      queue_request(OP_TEST, 8);
      queue_request(OP_SET, 7);
      queue_request(OP_FIND, 0);

      // zero size: only clear all and no-ops succeed
      write_size(13'd0);
      queue_request(OP_TEST, 0);
      queue_request(OP_FIND, 0);
      queue_request(OP_CLR_ALL, 0);
      queue_request(OP_SPARE_MID, 0);

      // random phases over several sizes
      write_size(13'd4096);
      want_backlog = 1'b1;
      run_random(160);

      write_size(13'd8191);
      no_idle = 1'b1;
      run_random(120);
      wait_drained();
      no_idle = 1'b0;

      write_size(13'd1);
      run_random(40);

      write_size(13'd100);
      run_random(130);

      write_size(SIZE_W'($urandom_range(0, 8191)));
      run_random(120);

      write_size(13'd4096);
      want_backlog = 1'b1;
      run_random(140);

      wait_drained();
      repeat (10) @(posedge clock);

      $display("covered %0d requests: %0d finds hit, %0d finds empty, %0d out of range",
               n_checked, finds_hit, finds_none, out_of_range);
      $display("sizes 0, 1, 8, 100, 4096, 8191 and one random, with output hold-off");
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

@@ bitmap_set_clear_find_next_unit.f @@
rtl/bscfn_pkg.sv
rtl/bscfn_chan_if.sv
rtl/bscfn_front.sv
rtl/bscfn_cmd_fifo.sv
rtl/bscfn_back.sv
rtl/bitmap_set_clear_find_next_unit.sv
sim/tb_top.sv
